>>> rtl/ipt_pkg.sv
// Package for the interval paint table: entry and classification types, command codes.
// No dependencies; used by ipt_classify and interval_paint_table_unit.
package ipt_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ACT_KEEP  = 2'd0;
    localparam logic [1:0] ACT_DROP  = 2'd1;
    localparam logic [1:0] ACT_SPLIT = 2'd2;

    typedef struct packed {
        logic signed [31:0] t_start;
        logic signed [31:0] t_end;
        logic        [3:0]  tag;
    } t_entry;

    typedef struct packed {
        logic [1:0] act;
        t_entry     kept;
        t_entry     piece;
    } t_cls;

endpackage

>>> rtl/interval_paint_table_unit.sv
// Top level of the interval paint table: ping-pong entry memory and walk sequencer.
// Depends on ipt_pkg and ipt_classify.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | i_valid / o_stall  | i_cmd, i_range_start, i_range_end, i_tag_in,
//          |                    | i_query_time
//  output  | o_valid / i_stall  | o_status, o_found, o_tag_out, o_entry_count
//
// One memory holds two banks of DEPTH entries. Add and remove read the live
// bank one entry per cycle and write the edited list into the other bank;
// each split holds the read while its piece is classified. The banks swap
// only when the command succeeds, so a rejected command leaves the list as
// it was. Add, remove and query walk the stored entries in order through
// the single memory read port.
// Reset (synchronous, active low) empties the list; memory contents need none.
// A result waiting on i_stall does not block the next transfer in.
module interval_paint_table_unit #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_range_start,
    input  logic signed [31:0] i_range_end,
    input  logic [3:0]         i_tag_in,
    input  logic signed [31:0] i_query_time,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic               o_found,
    output logic [3:0]         o_tag_out,
    output logic [5:0]         o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLS  = 3'd1;
    localparam logic [2:0] S_QRY  = 3'd2;
    localparam logic [2:0] S_APP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // entry memory: two banks, selected by the top address bit
    ipt_pkg::t_entry mem [2**(AW+1)];

    logic [2:0]         r_state, n_state;
    logic               r_bank, n_bank;
    logic [CW-1:0]      r_len, n_len;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_w, n_w;
    logic               r_from_mem, n_from_mem;
    ipt_pkg::t_entry    r_cur, n_cur;
    ipt_pkg::t_entry    r_rdq;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_ns, r_ne, r_qt;
    logic [3:0]         r_tag;
    logic               r_res_st, n_res_st;
    logic               r_res_fd, n_res_fd;
    logic [3:0]         r_res_tg, n_res_tg;
    logic [CW-1:0]      r_res_cnt, n_res_cnt;
    logic               r_ovld, n_ovld;
    logic               r_ost, r_ofd;
    logic [3:0]         r_otg;
    logic [5:0]         r_ocnt;

    logic               accept;
    logic [CW-1:0]      idx_next;
    logic [AW-1:0]      rd_idx;
    logic               wr_en;
    logic [AW-1:0]      wr_idx;
    ipt_pkg::t_entry    wr_data;
    ipt_pkg::t_entry    cur;
    ipt_pkg::t_cls      cls;
    logic [CW:0]        n_work;
    logic               more;
    logic               load_out;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign idx_next = r_idx + CW'(1);
    assign more     = (idx_next < r_len);
    assign cur      = r_from_mem ? r_rdq : r_cur;
    assign n_work   = (CW+1)'(r_w) + (CW+1)'(r_len) - (CW+1)'(r_idx);

    // in idle keep entry 0 of the live bank on the read register
    assign rd_idx = (r_state == S_IDLE) ? '0 : idx_next[AW-1:0];

    ipt_classify u_cls (
        .i_cur (cur),
        .i_ns  (r_ns),
        .i_ne  (r_ne),
        .o_cls (cls)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[{~r_bank, wr_idx}] <= wr_data;
        end
        r_rdq <= mem[{r_bank, rd_idx}];
    end

    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_len      = r_len;
        n_idx      = r_idx;
        n_w        = r_w;
        n_from_mem = r_from_mem;
        n_cur      = r_cur;
        n_res_st   = r_res_st;
        n_res_fd   = r_res_fd;
        n_res_tg   = r_res_tg;
        n_res_cnt  = r_res_cnt;
        wr_en      = 1'b0;
        wr_idx     = r_w[AW-1:0];
        wr_data    = cls.kept;
        load_out   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx      = '0;
                    n_w        = '0;
                    n_from_mem = 1'b1;
                    n_res_st   = 1'b0;
                    n_res_fd   = 1'b0;
                    n_res_tg   = '0;
                    n_res_cnt  = r_len;
                    if (i_cmd == ipt_pkg::CMD_ADD || i_cmd == ipt_pkg::CMD_REMOVE) begin
                        n_state = (r_len == '0) ? S_APP : S_CLS;
                    end else if (i_cmd == ipt_pkg::CMD_QUERY) begin
                        n_state = (r_len == '0) ? S_FIN : S_QRY;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CLS: begin
                if (cls.act == ipt_pkg::ACT_SPLIT) begin
                    if (n_work >= (CW+1)'(DEPTH)) begin
                        // overflow: drop the edit, the live bank is untouched
                        n_res_st = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        wr_en      = 1'b1;
                        n_w        = r_w + CW'(1);
                        n_cur      = cls.piece;
                        n_from_mem = 1'b0;
                    end
                end else begin
                    if (cls.act == ipt_pkg::ACT_KEEP) begin
                        wr_en = 1'b1;
                        n_w   = r_w + CW'(1);
                    end
                    if (more) begin
                        n_idx      = idx_next;
                        n_from_mem = 1'b1;
                    end else begin
                        n_state = S_APP;
                    end
                end
            end
            S_QRY: begin
                if (r_rdq.t_start <= r_qt && r_rdq.t_end >= r_qt) begin
                    n_res_fd = 1'b1;
                    n_res_tg = r_rdq.tag;
                    n_state  = S_FIN;
                end else if (more) begin
                    n_idx = idx_next;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_APP: begin
                n_state = S_FIN;
                if (r_cmd == ipt_pkg::CMD_ADD) begin
                    if (r_w >= CW'(DEPTH)) begin
                        n_res_st = 1'b1;
                    end else begin
                        wr_en     = 1'b1;
                        wr_data   = '{t_start: r_ns, t_end: r_ne, tag: r_tag};
                        n_len     = r_w + CW'(1);
                        n_res_cnt = r_w + CW'(1);
                        n_bank    = ~r_bank;
                    end
                end else begin
                    n_len     = r_w;
                    n_res_cnt = r_w;
                    n_bank    = ~r_bank;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_ovld || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovld = r_ovld && i_stall;
        if (load_out) begin
            n_ovld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_len   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_len   <= n_len;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_w        <= n_w;
        r_from_mem <= n_from_mem;
        r_cur      <= n_cur;
        r_res_st   <= n_res_st;
        r_res_fd   <= n_res_fd;
        r_res_tg   <= n_res_tg;
        r_res_cnt  <= n_res_cnt;
        if (accept) begin
            r_cmd <= i_cmd;
            r_ns  <= i_range_start;
            r_ne  <= i_range_end;
            r_tag <= i_tag_in;
            r_qt  <= i_query_time;
        end
        if (load_out) begin
            r_ost  <= r_res_st;
            r_ofd  <= r_res_fd;
            r_otg  <= r_res_tg;
            r_ocnt <= 6'(r_res_cnt);
        end
    end

    assign o_valid       = r_ovld;
    assign o_status      = r_ost;
    assign o_found       = r_ofd;
    assign o_tag_out     = r_otg;
    assign o_entry_count = r_ocnt;

endmodule

>>> rtl/ipt_classify.sv
// Classifies one stored entry against the interval being painted.
// Depends on ipt_pkg.
module ipt_classify (
    input  ipt_pkg::t_entry    i_cur,
    input  logic signed [31:0] i_ns,
    input  logic signed [31:0] i_ne,
    output ipt_pkg::t_cls      o_cls
);

    logic signed [31:0] os;
    logic signed [31:0] oe;

    assign os = i_cur.t_start;
    assign oe = i_cur.t_end;

    always_comb begin
        o_cls.act         = ipt_pkg::ACT_KEEP;
        o_cls.kept        = i_cur;
        o_cls.piece.t_start = i_ne;
        o_cls.piece.t_end   = oe;
        o_cls.piece.tag     = i_cur.tag;
        if (os > i_ne || oe < i_ns) begin
            o_cls.act = ipt_pkg::ACT_KEEP;
        end else if (i_ns <= oe && i_ns <= os && i_ne >= oe && i_ne >= os) begin
            o_cls.act = ipt_pkg::ACT_DROP;
        end else if (os <= i_ne && os <= i_ns && oe >= i_ne && oe >= i_ns) begin
            // keep the left part, the right part goes on as a piece
            o_cls.act        = ipt_pkg::ACT_SPLIT;
            o_cls.kept.t_end = i_ns;
        end else if (i_ns <= os && i_ne < oe) begin
            o_cls.kept.t_start = i_ne;
        end else if (i_ns > os && i_ne > oe) begin
            o_cls.kept.t_end = i_ns;
        end
    end

endmodule

>>> tb/ipt_checker.sv
// Result checker for the interval paint table: watches both channels, keeps its own
// copy of the interval list and compares every result. Depends on ipt_pkg.
module ipt_checker #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_range_start,
    input  logic signed [31:0] i_range_end,
    input  logic [3:0]         i_tag_in,
    input  logic signed [31:0] i_query_time,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic               o_status,
    input  logic               o_found,
    input  logic [3:0]         o_tag_out,
    input  logic [5:0]         o_entry_count,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 reject_count,
    output int                 hit_count,
    output int                 split_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       status;
        logic       found;
        logic [3:0] tag;
        logic [5:0] count;
    } t_answer;

    ipt_pkg::t_entry table_list[$];
    t_answer         answer_q[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        result_count  = 0;
        reject_count  = 0;
        hit_count     = 0;
        split_count   = 0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Edit a copy of the list; return 0 when a split or the append would overflow.
    function automatic bit paint(input logic signed [31:0] ns, input logic signed [31:0] ne,
                                 input bit append, input logic [3:0] tag);
        ipt_pkg::t_entry work[$];
        ipt_pkg::t_entry cur;
        ipt_pkg::t_entry piece;
        int i;
        work = table_list;
        i = 0;
        while (i < work.size()) begin
            cur = work[i];
            if (cur.t_start > ne || cur.t_end < ns) begin
                i++;
            end else if (ns <= cur.t_start && ne >= cur.t_end) begin
                work.delete(i);
            end else if (cur.t_start <= ns && cur.t_end >= ne) begin
                if (work.size() >= DEPTH) return 0;
                piece = '{t_start: ne, t_end: cur.t_end, tag: cur.tag};
                work[i].t_end = ns;
                work.insert(i + 1, piece);
                split_count++;
                i++;
            end else if (ns <= cur.t_start && ne < cur.t_end) begin
                work[i].t_start = ne;
                i++;
            end else if (ns > cur.t_start && ne > cur.t_end) begin
                work[i].t_end = ns;
                i++;
            end else begin
                i++;
            end
        end
        if (append) begin
            if (work.size() >= DEPTH) return 0;
            piece = '{t_start: ns, t_end: ne, tag: tag};
            work.insert(work.size(), piece);
        end
        table_list = work;
        return 1;
    endfunction

    function automatic t_answer predict(input logic [1:0] cmd, input logic signed [31:0] ns,
                                        input logic signed [31:0] ne, input logic [3:0] tag,
                                        input logic signed [31:0] qt);
        t_answer a;
        a = '0;
        if (cmd == ipt_pkg::CMD_ADD || cmd == ipt_pkg::CMD_REMOVE) begin
            if (!paint(ns, ne, cmd == ipt_pkg::CMD_ADD, tag)) a.status = 1'b1;
        end else if (cmd == ipt_pkg::CMD_QUERY) begin
            foreach (table_list[k]) begin
                if (table_list[k].t_start <= qt && table_list[k].t_end >= qt) begin
                    a.found = 1'b1;
                    a.tag = table_list[k].tag;
                    break;
                end
            end
        end
        a.count = 6'(table_list.size());
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            table_list.delete();
            answer_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                result_count++;
                if (answer_q.size() == 0) begin
                    $display("[%0t] result with nothing outstanding", $realtime);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_status !== want.status) report("status", o_status, want.status);
                    if (o_found !== want.found) report("found", o_found, want.found);
                    if (o_tag_out !== want.tag) report("tag_out", o_tag_out, want.tag);
                    if (o_entry_count !== want.count)
                        report("entry_count", o_entry_count, want.count);
                end
            end
            if (i_valid && !o_stall) begin
                want = predict(i_cmd, i_range_start, i_range_end, i_tag_in, i_query_time);
                if (want.status) reject_count++;
                if (want.found) hit_count++;
                answer_q.insert(answer_q.size(), want);
            end
        end
        pending_count = answer_q.size();
    end
endmodule

>>> tb/testbench.sv
// Top of the interval paint table bench: clock, reset, command stimulus and verdict.
// Depends on ipt_pkg, interval_paint_table_unit and ipt_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int RANDOM_CMDS = 900;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd = ipt_pkg::CMD_QUERY;
    logic signed [31:0] i_range_start = '0;
    logic signed [31:0] i_range_end = '0;
    logic [3:0]         i_tag_in = '0;
    logic signed [31:0] i_query_time = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_status;
    logic               o_found;
    logic [3:0]         o_tag_out;
    logic [5:0]         o_entry_count;

    int fail_count, pending_count, result_count, reject_count, hit_count, split_count;
    int sent_count = 0;
    bit hold_off = 1'b0;   // long receiver hold-off, raised by the stimulus process

    // 12 ns period: 6 high, 6 low
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    interval_paint_table_unit #(.DEPTH(DEPTH)) i_dut (.*);

    ipt_checker #(.DEPTH(DEPTH)) i_checker (.*);

    // Receiver: stall on its own pattern. Phases alternate between no stall,
    // light random stall and heavy random stall so gaps land on every cycle of a walk.
    initial begin
        int phase_left;
        int mode;
        phase_left = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                mode = $urandom_range(2);
                phase_left = $urandom_range(200, 20);
            end
            phase_left--;
            if (hold_off) i_stall <= 1'b1;
            else if (mode == 0) i_stall <= 1'b0;
            else if (mode == 1) i_stall <= ($urandom_range(3) == 0);
            else i_stall <= ($urandom_range(3) != 0);
        end
    end

    // Hold the output for a long stretch once the request comes, counted here in cycles.
    initial begin
        wait (hold_off);
        repeat (400) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // Sender bursts: offer one command, hold it until the transfer, then maybe gap.
    int burst_left = 0;

    task automatic send(input logic [1:0] cmd, input logic signed [31:0] rs,
                        input logic signed [31:0] re, input logic [3:0] tag,
                        input logic signed [31:0] qt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            if ($urandom_range(3) == 0) begin
                // drop valid for the gap between bursts
                i_valid <= 1'b0;
                repeat ($urandom_range(30, 1)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_range_start <= rs;
        i_range_end <= re;
        i_tag_in <= tag;
        i_query_time <= qt;
        // advance until the transfer happens at a rising edge
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Small window of time points so intervals overlap often; sometimes full-range values.
    function automatic logic signed [31:0] pick_time();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(200)) - 32'sd100;
        endcase
    endfunction

    task automatic send_random();
        logic signed [31:0] a, b, t;
        int pick;
        a = pick_time();
        b = pick_time();
        // mostly well-formed intervals; inverted and degenerate ones are rare noise
        if (a > b && $urandom_range(19) != 0) begin
            t = a; a = b; b = t;
        end
        if (a == b && $urandom_range(3) != 0) b = a + 32'sd1;
        pick = $urandom_range(19);
        if (pick < 8) send(ipt_pkg::CMD_ADD, a, b, 4'($urandom), pick_time());
        else if (pick < 11) send(ipt_pkg::CMD_REMOVE, a, b, 4'($urandom), pick_time());
        else if (pick < 19) send(ipt_pkg::CMD_QUERY, a, b, 4'($urandom), pick_time());
        else send(ipt_pkg::CMD_UNUSED, $urandom, $urandom, 4'($urandom), $urandom);
    endtask

    initial begin
        int idle;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, every command, splits, trims, shared points,
        // degenerate and inverted intervals, unused command, overflow.
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 0);                          // empty list
        send(ipt_pkg::CMD_ADD, 32'sh80000000, 32'sh7fffffff, 4'hf, 0); // whole range
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 32'sh80000000);
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 32'sh7fffffff);
        send(ipt_pkg::CMD_ADD, -10, 10, 4'h5, 0);                      // split the whole range
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, -10);                        // shared point
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 0);
        send(ipt_pkg::CMD_ADD, -20, -5, 4'ha, 0);                      // trims
        send(ipt_pkg::CMD_ADD, 5, 30, 4'h3, 0);
        send(ipt_pkg::CMD_REMOVE, -8, 8, 4'h0, 0);
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 20);
        send(ipt_pkg::CMD_ADD, 50, 50, 4'h1, 0);                       // degenerate inside
        send(ipt_pkg::CMD_ADD, 60, 40, 4'h2, 0);                       // inverted inside
        send(ipt_pkg::CMD_REMOVE, 32'sh80000000, 32'sh7fffffff, 0, 0); // cover everything
        send(ipt_pkg::CMD_UNUSED, 32'shffffffff, 32'shffffffff, 4'hf, 32'shffffffff);
        send(ipt_pkg::CMD_ADD, 100, 90, 4'h6, 0);                      // store an inverted entry
        send(ipt_pkg::CMD_ADD, 95, 96, 4'h7, 0);                       // inverted entry classed as disjoint, kept
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 95);
        for (int k = 0; k < DEPTH + 1; k++)                            // fill to overflow
            send(ipt_pkg::CMD_ADD, 1000 + 4 * k, 1001 + 4 * k, 4'(k), 0);
        send(ipt_pkg::CMD_QUERY, 0, 0, 0, 1001);
        send(ipt_pkg::CMD_REMOVE, 32'sh80000000, 32'sh7fffffff, 0, 0);

        // Random part; partway through, hold the receiver off to back up the block.
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (k == RANDOM_CMDS / 3) hold_off = 1'b1;
            // clear the list now and then so the table does not stay pinned full
            if ($urandom_range(79) == 0)
                send(ipt_pkg::CMD_REMOVE, 32'sh80000000, 32'sh7fffffff, 0, 0);
            else
                send_random();
        end
        i_valid <= 1'b0;

        idle = 0;
        while (pending_count != 0 && idle < 20000) begin
            @(negedge i_clk);
            idle++;
        end
        repeat (80) @(negedge i_clk);
        $display("Sent %0d commands, checked %0d results: %0d rejected, %0d query hits,",
                 sent_count, result_count, reject_count, hit_count);
        $display("%0d entry splits predicted, with bursty input and random output stall.",
                 split_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Run limit: ~1000 commands, each with its walk plus stall and gaps.
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/ipt_pkg.sv
rtl/ipt_classify.sv
rtl/interval_paint_table_unit.sv
tb/ipt_checker.sv
tb/testbench.sv
